// ----- rtl/core/scsvf_pkg.sv -----
// shared types and constants for the soft clipped state variable filter
`default_nettype none
package scsvf_pkg;

   localparam int StateFracBitsDefault = 24;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 16;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegCoefGA    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegCoefGB    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegDampingA  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegDampingB  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegDriveA    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegDriveB    = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegFilterMode = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegOutputGain = 3'd7;

   // response modes
   localparam logic [1:0] ModeLowpass  = 2'd0;
   localparam logic [1:0] ModeHighpass = 2'd1;
   localparam logic [1:0] ModeBandpass = 2'd2;
   localparam logic [1:0] ModeBypass   = 2'd3;

   // register reset values
   localparam logic [15:0] CoefGReset   = 16'd1697;
   localparam logic [15:0] DampingReset = 16'd29491;
   localparam logic [15:0] DriveReset   = 16'd3277;
   localparam logic [15:0] GainReset    = 16'd4096;

   // damping forced to one at or above this tuning coefficient
   localparam logic [15:0] GLimit = 16'd24977;
   localparam logic [15:0] DampingOne = 16'd32768;

   typedef struct packed {
      logic        start;
      logic        op_div;
      logic [63:0] opa;
      logic [63:0] opb;
   } scsvf_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } scsvf_sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/scsvf_chan_if.sv -----
// sample and result channel interfaces of the soft clipped state variable filter
`default_nettype none
interface scsvf_req_if;
   logic               valid;
   logic               ready;
   logic               filter_select;
   logic signed [15:0] sample_in;
   modport source (output valid, output filter_select, output sample_in, input ready);
   modport sink (input valid, input filter_select, input sample_in, output ready);
endinterface

interface scsvf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/scsvf_mdu.sv -----
// shared bit serial multiply and divide unit
`default_nettype none
module scsvf_mdu (
   input  logic                    clock,
   input  logic                    reset,
   input  scsvf_pkg::scsvf_cmd_type cmd,
   output scsvf_pkg::scsvf_sts_type sts
);
   import scsvf_pkg::*;

   localparam int DivSteps = 64;
   localparam int CntWidth = $clog2(DivSteps + 1);

   logic                busy_ff, busy_in;
   logic                div_ff, div_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [63:0]         acc_ff, acc_in;
   logic [63:0]         a_ff, a_in;
   logic [63:0]         b_ff, b_in;
   logic [63:0]         rem_ff, rem_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [64:0]         rem_sh;
   logic [65:0]         diff;
   logic                ge;

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      rem_sh  = {rem_ff, a_ff[63]};
      diff    = {1'b0, rem_sh} - {2'b00, b_ff};
      ge      = !diff[65];
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.op_div;
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = CntWidth'(DivSteps);
         neg_in  = cmd.opa[63];
         if (cmd.op_div) begin
            // divide magnitude, sign restored at the end (truncates toward zero)
            a_in = cmd.opa[63] ? (~cmd.opa + 64'd1) : cmd.opa;
            b_in = cmd.opb;
         end else begin
            a_in = cmd.opa;
            b_in = {32'd0, cmd.opb[31:0]};
         end
      end else if (busy_ff) begin
         if (!div_ff) begin
            if (b_ff == 64'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               acc_in = acc_ff + (b_ff[0] ? a_ff : 64'd0);
               a_in   = {a_ff[62:0], 1'b0};
               b_in   = {1'b0, b_ff[63:1]};
            end
         end else begin
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               acc_in  = neg_ff ? (~a_ff + 64'd1) : a_ff;
            end else begin
               a_in   = {a_ff[62:0], ge};
               rem_in = ge ? diff[63:0] : rem_sh[63:0];
               cnt_in = cnt_ff - CntWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = acc_ff;

endmodule
`default_nettype wire

// ----- rtl/core/soft_clipped_state_variable_filter.sv -----
// top level of the two instance soft clipped state variable filter
//
// Each req beat carries one Q1.15 sample and an instance select; one rsp beat
// comes back per sample. A sequencer walks the drive, soft clip, loop solve,
// state update and output steps through one shared unit that multiplies one
// bit per cycle (stopping when the multiplier runs out of ones, at most 32
// steps) and divides one bit per cycle (64 steps). Each sample runs four
// divides, plus a fifth for lowpass when the output is inside the tanh limit;
// multiply time depends on how many bits the multipliers carry. req ready is
// held low meanwhile. A finished result sits in the rsp register, so the next
// sample is taken while it waits. Register writes go straight in and are
// expected only while no sample is in flight.
`default_nettype none
module soft_clipped_state_variable_filter #(
   parameter int STATE_FRAC_BITS = scsvf_pkg::StateFracBitsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   scsvf_req_if.sink                             req_chan,
   scsvf_rsp_if.source                           rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [scsvf_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [scsvf_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import scsvf_pkg::*;

   localparam int Frac = STATE_FRAC_BITS;
   localparam int DrvShift = 28 - Frac;
   localparam int SqShift = 2 * Frac - 14;
   localparam int OutShift = Frac - 3;
   localparam logic signed [63:0] TanhLim = (64'sd195 <<< Frac) / 100;
   localparam logic signed [63:0] TanhBase = 64'sd429 <<< Frac;
   localparam logic signed [63:0] Int32Max = 64'sd2147483647;
   localparam logic signed [63:0] Int32Min = -64'sd2147483648;
   localparam logic signed [63:0] Int16Max = 64'sd32767;
   localparam logic signed [63:0] Int16Min = -64'sd32768;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_DRV    = 5'd1;
   localparam logic [4:0] ST_SC_SQ  = 5'd2;
   localparam logic [4:0] ST_SC_NUM = 5'd3;
   localparam logic [4:0] ST_SC_DEN = 5'd4;
   localparam logic [4:0] ST_SC_DIV = 5'd5;
   localparam logic [4:0] ST_SC_MUL = 5'd6;
   localparam logic [4:0] ST_GR     = 5'd7;
   localparam logic [4:0] ST_GG     = 5'd8;
   localparam logic [4:0] ST_N1     = 5'd9;
   localparam logic [4:0] ST_N2     = 5'd10;
   localparam logic [4:0] ST_N3     = 5'd11;
   localparam logic [4:0] ST_DY1    = 5'd12;
   localparam logic [4:0] ST_Y0N    = 5'd13;
   localparam logic [4:0] ST_DY0    = 5'd14;
   localparam logic [4:0] ST_R2     = 5'd15;
   localparam logic [4:0] ST_U1     = 5'd16;
   localparam logic [4:0] ST_U2     = 5'd17;
   localparam logic [4:0] ST_T1     = 5'd18;
   localparam logic [4:0] ST_T2     = 5'd19;
   localparam logic [4:0] ST_T3     = 5'd20;
   localparam logic [4:0] ST_TD     = 5'd21;
   localparam logic [4:0] ST_HPBP   = 5'd22;
   localparam logic [4:0] ST_FIN    = 5'd23;

   function automatic logic signed [63:0] shr_round(input logic signed [63:0] v, input int n);
      logic signed [63:0] t;
      if (n == 0) return v;
      t = v + (64'sd1 <<< (n - 1));
      return t >>> n;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > Int32Max) ? Int32Max : ((v < Int32Min) ? Int32Min : v);
      return c[31:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > Int16Max) ? Int16Max : ((v < Int16Min) ? Int16Min : v);
      return c[15:0];
   endfunction

   // configuration registers
   logic [15:0] coef_g_ff [2];
   logic [15:0] damping_ff [2];
   logic [15:0] drive_ff [2];
   logic [1:0]  mode_ff;
   logic [15:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_g_ff[0]  <= CoefGReset;
         coef_g_ff[1]  <= CoefGReset;
         damping_ff[0] <= DampingReset;
         damping_ff[1] <= DampingReset;
         drive_ff[0]   <= DriveReset;
         drive_ff[1]   <= DriveReset;
         mode_ff       <= ModeLowpass;
         gain_ff       <= GainReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            RegCoefGA:     coef_g_ff[0]  <= csr_wdata;
            RegCoefGB:     coef_g_ff[1]  <= csr_wdata;
            RegDampingA:   damping_ff[0] <= csr_wdata;
            RegDampingB:   damping_ff[1] <= csr_wdata;
            RegDriveA:     drive_ff[0]   <= csr_wdata;
            RegDriveB:     drive_ff[1]   <= csr_wdata;
            RegFilterMode: mode_ff       <= csr_wdata[1:0];
            RegOutputGain: gain_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer state and working registers
   logic [4:0]         state_ff, state_in;
   logic               issued_ff, issued_in;
   logic               sel_ff, sel_in;
   logic signed [15:0] smp_ff, smp_in;
   logic [15:0]        g_ff, g_in;
   logic [15:0]        r_ff, r_in;
   logic signed [31:0] s1_ff, s1_in;
   logic signed [31:0] s2_ff, s2_in;
   logic signed [31:0] int1_ff [2];
   logic signed [31:0] int1_in [2];
   logic signed [31:0] int2_ff [2];
   logic signed [31:0] int2_in [2];
   logic signed [63:0] x_ff, x_in;
   logic signed [63:0] d1_ff, d1_in;
   logic signed [63:0] d_ff, d_in;
   logic [31:0]        g2_ff, g2_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] y1_ff, y1_in;
   logic signed [63:0] y0_ff, y0_in;
   logic signed [63:0] sc1_ff, sc1_in;
   logic signed [63:0] r2y0_ff, r2y0_in;
   logic signed [63:0] sc_v_ff, sc_v_in;
   logic               sc_pass_ff, sc_pass_in;
   logic [28:0]        sc_a_ff, sc_a_in;
   logic [63:0]        sc_num_ff, sc_num_in;
   logic [63:0]        sc_den_ff, sc_den_in;
   logic [20:0]        sc_p_ff, sc_p_in;
   logic signed [15:0] res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_data_ff, rsp_data_in;

   scsvf_cmd_type      cmd;
   scsvf_sts_type      sts;

   logic               step;
   logic               finish;
   logic [63:0]        p;
   logic signed [63:0] ps;
   logic signed [63:0] xx;
   logic [63:0]        mag_v;
   logic [63:0]        mag_y;
   logic [63:0]        sq;
   logic signed [63:0] tmp;
   logic [15:0]        g_pick;

   scsvf_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      smp_in       = smp_ff;
      g_in         = g_ff;
      r_in         = r_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      int1_in      = int1_ff;
      int2_in      = int2_ff;
      x_in         = x_ff;
      d1_in        = d1_ff;
      d_in         = d_ff;
      g2_in        = g2_ff;
      acc_in       = acc_ff;
      y1_in        = y1_ff;
      y0_in        = y0_ff;
      sc1_in       = sc1_ff;
      r2y0_in      = r2y0_ff;
      sc_v_in      = sc_v_ff;
      sc_pass_in   = sc_pass_ff;
      sc_a_in      = sc_a_ff;
      sc_num_in    = sc_num_ff;
      sc_den_in    = sc_den_ff;
      sc_p_in      = sc_p_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      step         = (state_ff != ST_IDLE) && (state_ff != ST_FIN);
      finish       = step && issued_ff && sts.done;
      issued_in    = step ? (issued_ff ? !sts.done : 1'b1) : 1'b0;
      p            = sts.result;
      ps           = $signed(sts.result);
      xx           = x_ff - y1_ff;
      mag_v        = sc_v_ff[63] ? 64'(-sc_v_ff) : 64'(sc_v_ff);
      mag_y        = y1_ff[63] ? 64'(-y1_ff) : 64'(y1_ff);
      sq           = p >> SqShift;
      tmp          = '0;
      g_pick       = coef_g_ff[req_chan.filter_select];

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sel_in   = req_chan.filter_select;
               smp_in   = req_chan.sample_in;
               g_in     = g_pick;
               r_in     = (g_pick >= GLimit) ? DampingOne : damping_ff[req_chan.filter_select];
               s1_in    = int1_ff[req_chan.filter_select];
               s2_in    = int2_ff[req_chan.filter_select];
               state_in = ST_DRV;
            end
         end
         ST_DRV: begin
            cmd.opa = {{48{smp_ff[15]}}, smp_ff};
            cmd.opb = {48'd0, drive_ff[sel_ff]};
            if (finish) begin
               sc_v_in    = shr_round(ps, DrvShift);
               sc_pass_in = 1'b0;
               state_in   = ST_SC_SQ;
            end
         end
         ST_SC_SQ: begin
            cmd.opa = mag_v;
            cmd.opb = {32'd0, mag_v[31:0]};
            if (finish) begin
               // (v/2)^2 in Q16, held at 4096
               sc_a_in  = (sq > 64'd268435456) ? 29'd268435456 : sq[28:0];
               state_in = ST_SC_NUM;
            end
         end
         ST_SC_NUM: begin
            cmd.opa = {35'd0, sc_a_ff} + (64'd105 << 16);
            cmd.opb = {35'd0, sc_a_ff};
            if (finish) begin
               sc_num_in = (p >> 16) + (64'd945 << 16);
               state_in  = ST_SC_DEN;
            end
         end
         ST_SC_DEN: begin
            cmd.opa = ({35'd0, sc_a_ff} << 4) - {35'd0, sc_a_ff} + (64'd420 << 16);
            cmd.opb = {35'd0, sc_a_ff};
            if (finish) begin
               sc_den_in = (p >> 16) + (64'd945 << 16);
               state_in  = ST_SC_DIV;
            end
         end
         ST_SC_DIV: begin
            cmd.op_div = 1'b1;
            cmd.opa    = sc_num_ff << 20;
            cmd.opb    = sc_den_ff;
            if (finish) begin
               sc_p_in  = p[20:0];
               state_in = ST_SC_MUL;
            end
         end
         ST_SC_MUL: begin
            cmd.opa = sc_v_ff;
            cmd.opb = {43'd0, sc_p_ff};
            if (finish) begin
               tmp = shr_round(ps, 20);
               if (sc_pass_ff) begin
                  sc1_in   = tmp;
                  state_in = ST_Y0N;
               end else begin
                  x_in     = tmp;
                  state_in = ST_GR;
               end
            end
         end
         ST_GR: begin
            cmd.opa = {48'd0, g_ff};
            cmd.opb = {48'd0, r_ff};
            if (finish) begin
               d1_in    = $signed(64'd16777216 + ((p + 64'd2) >> 2));
               state_in = ST_GG;
            end
         end
         ST_GG: begin
            cmd.opa = {48'd0, g_ff};
            cmd.opb = {48'd0, g_ff};
            if (finish) begin
               g2_in    = p[31:0];
               d_in     = d1_ff + ps;
               state_in = ST_N1;
            end
         end
         ST_N1: begin
            cmd.opa = x_ff;
            cmd.opb = {32'd0, g2_ff};
            if (finish) begin
               acc_in   = ps;
               state_in = ST_N2;
            end
         end
         ST_N2: begin
            cmd.opa = {{32{s2_ff[31]}}, s2_ff};
            cmd.opb = {32'd0, d1_ff[31:0]};
            if (finish) begin
               acc_in   = acc_ff + ps;
               state_in = ST_N3;
            end
         end
         ST_N3: begin
            cmd.opa = {{32{s1_ff[31]}}, s1_ff} << 12;
            cmd.opb = {48'd0, g_ff};
            if (finish) begin
               acc_in   = acc_ff + ps;
               state_in = ST_DY1;
            end
         end
         ST_DY1: begin
            cmd.op_div = 1'b1;
            cmd.opa    = acc_ff;
            cmd.opb    = d_ff;
            if (finish) begin
               // second soft clip pass runs on the first integrator
               y1_in      = ps;
               sc_v_in    = {{32{s1_ff[31]}}, s1_ff};
               sc_pass_in = 1'b1;
               state_in   = ST_SC_SQ;
            end
         end
         ST_Y0N: begin
            cmd.opa = xx << 12;
            cmd.opb = {48'd0, g_ff};
            if (finish) begin
               acc_in   = (sc1_ff <<< 24) + ps;
               state_in = ST_DY0;
            end
         end
         ST_DY0: begin
            cmd.op_div = 1'b1;
            cmd.opa    = acc_ff;
            cmd.opb    = d1_ff;
            if (finish) begin
               y0_in    = ps;
               state_in = ST_R2;
            end
         end
         ST_R2: begin
            cmd.opa = y0_ff << 1;
            cmd.opb = {48'd0, r_ff};
            if (finish) begin
               r2y0_in  = shr_round(ps, 15);
               state_in = ST_U1;
            end
         end
         ST_U1: begin
            cmd.opa = (xx - r2y0_ff) << 1;
            cmd.opb = {48'd0, g_ff};
            if (finish) begin
               int1_in[sel_ff] = sat32(sc1_ff + shr_round(ps, 12));
               state_in        = ST_U2;
            end
         end
         ST_U2: begin
            cmd.opa = y0_ff << 1;
            cmd.opb = {48'd0, g_ff};
            if (finish) begin
               int2_in[sel_ff] = sat32({{32{s2_ff[31]}}, s2_ff} + shr_round(ps, 12));
               case (mode_ff) inside
                  ModeLowpass: begin
                     if (y1_ff < -TanhLim) begin
                        res_in   = sat16(Int16Min);
                        state_in = ST_FIN;
                     end else if (y1_ff > TanhLim) begin
                        res_in   = sat16(Int16Max);
                        state_in = ST_FIN;
                     end else begin
                        state_in = ST_T1;
                     end
                  end
                  ModeHighpass, ModeBandpass: state_in = ST_HPBP;
                  default: begin
                     res_in   = smp_ff;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_T1: begin
            cmd.opa = mag_y;
            cmd.opb = {32'd0, mag_y[31:0]};
            if (finish) begin
               sc_den_in = p >> Frac;
               state_in  = ST_T2;
            end
         end
         ST_T2: begin
            cmd.opa = sc_den_ff;
            cmd.opb = 64'd100;
            if (finish) begin
               sc_den_in = 64'(TanhBase) + p;
               state_in  = ST_T3;
            end
         end
         ST_T3: begin
            cmd.opa = y1_ff;
            cmd.opb = 64'd415;
            if (finish) begin
               acc_in   = ps <<< 15;
               state_in = ST_TD;
            end
         end
         ST_TD: begin
            cmd.op_div = 1'b1;
            cmd.opa    = acc_ff;
            cmd.opb    = sc_den_ff;
            if (finish) begin
               res_in   = sat16(ps);
               state_in = ST_FIN;
            end
         end
         ST_HPBP: begin
            cmd.opa = (mode_ff == ModeHighpass) ? (xx - r2y0_ff) : y0_ff;
            cmd.opb = {48'd0, gain_ff};
            if (finish) begin
               res_in   = sat16(shr_round(ps, OutShift));
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      cmd.start = step && !issued_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         int1_ff[0]   <= '0;
         int1_ff[1]   <= '0;
         int2_ff[0]   <= '0;
         int2_ff[1]   <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         int1_ff      <= int1_in;
         int2_ff      <= int2_in;
      end
      sel_ff      <= sel_in;
      smp_ff      <= smp_in;
      g_ff        <= g_in;
      r_ff        <= r_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      x_ff        <= x_in;
      d1_ff       <= d1_in;
      d_ff        <= d_in;
      g2_ff       <= g2_in;
      acc_ff      <= acc_in;
      y1_ff       <= y1_in;
      y0_ff       <= y0_in;
      sc1_ff      <= sc1_in;
      r2y0_ff     <= r2y0_in;
      sc_v_ff     <= sc_v_in;
      sc_pass_ff  <= sc_pass_in;
      sc_a_ff     <= sc_a_in;
      sc_num_ff   <= sc_num_in;
      sc_den_ff   <= sc_den_in;
      sc_p_ff     <= sc_p_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_DRV))
      else $error("accepted beat did not start the sequence");

   a_idle_no_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !issued_ff)
      else $error("unit operation outstanding while idle");

   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> issued_ff)
      else $error("unit finished an operation nobody issued");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not moved into the rsp register");

endmodule
`default_nettype wire

// ----- sim/soft_clipped_state_variable_filter_tb.sv -----
// self-checking testbench for the soft clipped state variable filter
`default_nettype none
module soft_clipped_state_variable_filter_tb;
   import scsvf_pkg::*;

   localparam int FracBits = StateFracBitsDefault;
   localparam int RandomSettings = 12;
   localparam int ItemsPerSetting = 145;

   typedef struct packed {
      logic               wr;
      logic [2:0]         idx;
      logic [15:0]        val;
      logic               sel;
      logic signed [15:0] smp;
      logic               known;
      logic signed [15:0] res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   scsvf_req_if req_chan ();
   scsvf_rsp_if rsp_chan ();

   soft_clipped_state_variable_filter dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // filter state and registers as the block should hold them
   logic [15:0] tune_g [2];
   logic [15:0] damp_r [2];
   logic [15:0] drive_k [2];
   logic [1:0] mode_q;
   logic [15:0] gain_q;
   logic signed [31:0] integ_one [2];
   logic signed [31:0] integ_two [2];

   logic signed [15:0] expected_samples [$];
   int send_idle = 37;
   int recv_idle = 66;
   int mismatches = 0;
   int unexpected = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int mode_hits [4] = '{0, 0, 0, 0};
   int override_hits = 0;

   function automatic longint round_shift(longint v, int n);
      if (n == 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // pade tanh soft clip, square saturated before the ratio
   function automatic longint pade_clip(longint v);
      longint unsigned mag, a16, num, den, p20;
      mag = (v < 0) ? -v : v;
      a16 = (mag * mag) >> (2 * FracBits - 14);
      if (a16 > (64'd4096 << 16)) a16 = 64'd4096 << 16;
      num = (((a16 + (64'd105 << 16)) * a16) >> 16) + (64'd945 << 16);
      den = (((64'd15 * a16 + (64'd420 << 16)) * a16) >> 16) + (64'd945 << 16);
      p20 = (num << 20) / den;
      return round_shift(v * longint'(p20), 20);
   endfunction

   function automatic longint tanh_q15(longint y);
      longint lim, y2, den;
      lim = (64'sd195 <<< FracBits) / 100;
      if (y < -lim) return -32768;
      if (y > lim) return 32768;
      y2 = (y * y) >>> FracBits;
      den = 64'sd429 * (64'sd1 <<< FracBits) + 64'sd100 * y2;
      return (64'sd415 * 32768 * y) / den;
   endfunction

   function automatic logic signed [15:0] filter_sample(logic sel, logic signed [15:0] smp);
      longint gi, ri, s1, s2, x, d1, g2, g24, d, y1, xx, sc1, y0, r2y0, res;
      gi = tune_g[sel];
      ri = (tune_g[sel] >= GLimit) ? longint'(DampingOne) : longint'(damp_r[sel]);
      if (tune_g[sel] >= GLimit) override_hits++;
      s1 = integ_one[sel];
      s2 = integ_two[sel];
      x = pade_clip(round_shift(longint'(smp) * longint'(drive_k[sel]), 28 - FracBits));
      d1 = (64'sd1 <<< 24) + ((gi * ri + 2) >>> 2);
      g2 = gi * gi;
      g24 = gi * 4096;
      d = d1 + g2;
      y1 = (g2 * x + d1 * s2 + g24 * s1) / d;
      xx = x - y1;
      sc1 = pade_clip(s1);
      y0 = (sc1 * (64'sd1 <<< 24) + g24 * xx) / d1;
      r2y0 = round_shift(2 * ri * y0, 15);
      integ_one[sel] = 32'(clamp(sc1 + round_shift(2 * gi * (xx - r2y0), 12),
                                 -64'sd2147483648, 64'sd2147483647));
      integ_two[sel] = 32'(clamp(s2 + round_shift(2 * gi * y0, 12),
                                 -64'sd2147483648, 64'sd2147483647));
      mode_hits[mode_q]++;
      case (mode_q)
         ModeLowpass:  res = tanh_q15(y1);
         ModeHighpass: res = round_shift((x - r2y0 - y1) * longint'(gain_q), FracBits - 3);
         ModeBandpass: res = round_shift(y0 * longint'(gain_q), FracBits - 3);
         default:      res = smp;
      endcase
      return 16'(clamp(res, -32768, 32767));
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         RegCoefGA:     tune_g[0] = val;
         RegCoefGB:     tune_g[1] = val;
         RegDampingA:   damp_r[0] = val;
         RegDampingB:   damp_r[1] = val;
         RegDriveA:     drive_k[0] = val;
         RegDriveB:     drive_k[1] = val;
         RegFilterMode: mode_q = val[1:0];
         default:       gain_q = val;
      endcase
   endtask

   // valid stays high after the beat so back-to-back beats never toggle it
   task automatic send_sample(logic sel, logic signed [15:0] smp, logic known,
                              logic signed [15:0] res);
      int gap;
      logic signed [15:0] pred;
      gap = 0;
      while ($urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.filter_select <= sel;
      req_chan.sample_in <= smp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pred = filter_sample(sel, smp);
      expected_samples.push_back(known ? res : pred);
      beats_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value(int idx);
      case (idx)
         RegCoefGA, RegCoefGB:
            case ($urandom_range(5))
               0: return 16'd0;
               1: return 16'hFFFF;
               2: return GLimit;
               3: return GLimit - 16'd1;
               4: return 16'($urandom_range(8000));
               default: return 16'($urandom);
            endcase
         RegDampingA, RegDampingB:
            case ($urandom_range(4))
               0: return 16'd328;
               1: return DampingOne;
               2: return 16'($urandom_range(1)) ? 16'hFFFF : 16'd0;
               default: return 16'($urandom_range(32768, 328));
            endcase
         RegDriveA, RegDriveB:
            case ($urandom_range(4))
               0: return 16'd0;
               1: return 16'd49152;
               2: return 16'hFFFF;
               default: return 16'($urandom_range(49152));
            endcase
         RegFilterMode: return 16'($urandom);
         default:
            case ($urandom_range(3))
               0: return 16'd0;
               1: return 16'hFFFF;
               default: return 16'($urandom);
            endcase
      endcase
   endfunction

   // result side: random back-pressure and the scoreboard
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_samples.size() == 0) begin
               unexpected++;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat on rsp: sample_out %0d", rsp_chan.sample_out);
            end else begin
               want = expected_samples.pop_front();
               beats_checked++;
               if (rsp_chan.sample_out !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sample_out mismatch on beat %0d: expected %0d got %0d",
                              beats_checked, want, rsp_chan.sample_out);
               end
            end
         end
      end
   end

   initial begin
      #100_000_000;
      $display("soft_clipped_state_variable_filter regression: fail");
      $finish;
   end

   initial begin
      stim_row_type rows [21];
      int phase_len;
      rows = '{
         // zero input after reset gives silence in lowpass, then full-scale samples
         '{1'b0, RegCoefGA, 16'd0, 1'b0, 16'sd0, 1'b1, 16'sd0},
         '{1'b0, RegCoefGA, 16'd0, 1'b1, 16'sd0, 1'b1, 16'sd0},
         '{1'b0, RegCoefGA, 16'd0, 1'b0, 16'sd32767, 1'b0, 16'sd0},
         '{1'b0, RegCoefGA, 16'd0, 1'b0, -16'sd32768, 1'b0, 16'sd0},
         '{1'b0, RegCoefGA, 16'd0, 1'b1, 16'sd32767, 1'b0, 16'sd0},
         // full drive pushes the soft clip into saturation
         '{1'b1, RegDriveA, 16'd49152, 1'b0, 16'sd32767, 1'b0, 16'sd0},
         '{1'b0, RegCoefGA, 16'd0, 1'b0, -16'sd32768, 1'b0, 16'sd0},
         // damping forced to one at the tuning limit
         '{1'b1, RegCoefGA, GLimit, 1'b0, 16'sd12345, 1'b0, 16'sd0},
         '{1'b1, RegCoefGA, 16'hFFFF, 1'b0, -16'sd32768, 1'b0, 16'sd0},
         '{1'b0, RegCoefGA, 16'd0, 1'b0, 16'sd32767, 1'b0, 16'sd0},
         '{1'b1, RegFilterMode, 16'(ModeHighpass), 1'b1, 16'sd20000, 1'b0, 16'sd0},
         '{1'b0, RegCoefGA, 16'd0, 1'b0, -16'sd20000, 1'b0, 16'sd0},
         '{1'b1, RegOutputGain, 16'hFFFF, 1'b0, 16'sd32767, 1'b0, 16'sd0},
         '{1'b1, RegFilterMode, 16'(ModeBandpass), 1'b1, -16'sd32768, 1'b0, 16'sd0},
         '{1'b1, RegDampingB, 16'd0, 1'b1, 16'sd32767, 1'b0, 16'sd0},
         // zero output gain silences bandpass and highpass
         '{1'b1, RegOutputGain, 16'd0, 1'b1, 16'sd1000, 1'b1, 16'sd0},
         '{1'b1, RegFilterMode, 16'(ModeHighpass), 1'b0, 16'sd5, 1'b1, 16'sd0},
         // upper mode bits are dropped, leaving bypass
         '{1'b1, RegFilterMode, 16'hFFFF, 1'b0, -16'sd32768, 1'b1, -16'sd32768},
         '{1'b0, RegCoefGA, 16'd0, 1'b1, 16'sd32767, 1'b1, 16'sd32767},
         '{1'b0, RegCoefGA, 16'd0, 1'b0, 16'sd0, 1'b1, 16'sd0},
         '{1'b1, RegDriveB, 16'hFFFF, 1'b1, -16'sd1, 1'b1, -16'sd1}
      };
      for (int k = 0; k < 2; k++) begin
         tune_g[k] = CoefGReset;
         damp_r[k] = DampingReset;
         drive_k[k] = DriveReset;
         integ_one[k] = '0;
         integ_two[k] = '0;
      end
      mode_q = ModeLowpass;
      gain_q = GainReset;
      req_chan.valid = 1'b0;
      req_chan.filter_select = 1'b0;
      req_chan.sample_in = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) begin
         if (rows[r].wr) begin
            drain();
            csr_write(rows[r].idx, rows[r].val);
         end
         send_sample(rows[r].sel, rows[r].smp, rows[r].known, rows[r].res);
      end

      phase_len = RandomSettings * ItemsPerSetting / 3;
      for (int s = 0; s < RandomSettings; s++) begin
         drain();
         for (int idx = 0; idx < 8; idx++)
            csr_write(3'(idx), (s == 0) ? 16'd0 : pick_value(idx));
         // pin the mode so every response gets random traffic
         csr_write(RegFilterMode, 16'(s % 4) | (16'($urandom) & 16'hFFFC));
         for (int n = 0; n < ItemsPerSetting; n++) begin
            int step;
            logic signed [15:0] smp;
            step = s * ItemsPerSetting + n;
            send_idle = (step < phase_len) ? 37 : (step < 2 * phase_len) ? 66 : 0;
            recv_idle = (step < phase_len) ? 66 : (step < 2 * phase_len) ? 37 : 0;
            case ($urandom_range(19))
               0, 1: smp = 16'sh7FFF;
               2, 3: smp = 16'sh8000;
               4, 5, 6, 7, 8: smp = 16'($signed($urandom_range(1024)) - 512);
               default: smp = 16'($urandom);
            endcase
            send_sample(1'($urandom), smp, 1'b0, 16'sd0);
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("%0d of %0d samples over %0d register settings checked, %0d leftover, %0d unexpected",
               beats_checked, beats_sent, RandomSettings + 1, expected_samples.size(),
               unexpected);
      $display("beats per mode lp/hp/bp/bypass %0d/%0d/%0d/%0d, %0d with damping override",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], override_hits);
      if (mismatches == 0 && expected_samples.size() == 0)
         $display("soft_clipped_state_variable_filter regression: pass");
      else
         $display("soft_clipped_state_variable_filter regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
